/* sv/hwfs_pkg.sv */
// shared widths, types, codes and the log table of the windowed hmm scorer
`default_nettype none

package hwfs_pkg;

  localparam int unsigned NumStates  = 16;
  localparam int unsigned MaxWindow  = 64;
  localparam int unsigned FracBits   = 16;

  localparam int unsigned StW    = $clog2(NumStates);
  localparam int unsigned WinAW  = $clog2(MaxWindow);
  localparam int unsigned LenW   = WinAW + 1;
  localparam int unsigned ProbW  = 18;
  localparam int unsigned AlphaW = FracBits + 1;
  localparam int unsigned ProdW  = AlphaW + ProbW;
  localparam int unsigned AccW   = ProdW - FracBits + StW - 1;
  localparam int unsigned UProdW = AccW + ProbW;
  localparam int unsigned UW     = UProdW - FracBits;
  localparam int unsigned SW     = UW + StW;
  localparam int unsigned PW     = $clog2(SW);
  localparam int unsigned ScoreW = 32;
  localparam int unsigned MarginW = 16;

  localparam int Ln2Q16 = 45426;

  typedef logic [ProbW-1:0]         prob_t;
  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [StW-1:0]           state_idx_t;

  typedef enum logic [1:0] {
    KIND_TRANS = 2'd0,
    KIND_EMIS  = 2'd1,
    KIND_INIT  = 2'd2,
    KIND_OBS   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIN_LEN = 2'd0,
    REG_THRESH  = 2'd1,
    REG_MARGIN  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // ln(1 + k/32) in q16
  function automatic logic [15:0] ln_frac(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:  r = 16'd0;     5'd1:  r = 16'd2017;  5'd2:  r = 16'd3973;
      5'd3:  r = 16'd5873;  5'd4:  r = 16'd7719;  5'd5:  r = 16'd9515;
      5'd6:  r = 16'd11262; 5'd7:  r = 16'd12965; 5'd8:  r = 16'd14624;
      5'd9:  r = 16'd16242; 5'd10: r = 16'd17822; 5'd11: r = 16'd19364;
      5'd12: r = 16'd20870; 5'd13: r = 16'd22343; 5'd14: r = 16'd23784;
      5'd15: r = 16'd25193; 5'd16: r = 16'd26573; 5'd17: r = 16'd27924;
      5'd18: r = 16'd29248; 5'd19: r = 16'd30546; 5'd20: r = 16'd31818;
      5'd21: r = 16'd33067; 5'd22: r = 16'd34292; 5'd23: r = 16'd35494;
      5'd24: r = 16'd36675; 5'd25: r = 16'd37835; 5'd26: r = 16'd38975;
      5'd27: r = 16'd40095; 5'd28: r = 16'd41197; 5'd29: r = 16'd42280;
      5'd30: r = 16'd43345; 5'd31: r = 16'd44394;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/hmm_window_forward_scorer_unit.sv */
// windowed hmm scorer: table loads, symbol window and scaled forward pass
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | in        | in_valid_i/in_stall_o| kind, row, col, value, symbol
//  out     | out       | out_valid_o/out_stall_i | score, belongs
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  loads and short-window observe items start no pass and are taken whenever the block is idle
//  a full-window item runs the forward pass, one window step after another, paced
//  by the serial mac loop over the alpha and transition memories
//  and the one-bit-a-step divider
//  in_stall_o is high while a pass runs or its result waits for the output slot
//  reset clears window head and fill count and loads the register defaults; tables need no clearing
module hmm_window_forward_scorer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [3:0]                    row_i,
  input  wire logic [3:0]                    col_i,
  input  wire hwfs_pkg::prob_t               value_i,
  input  wire logic [3:0]                    symbol_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output hwfs_pkg::score_t                   score_o,
  output logic                               belongs_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import hwfs_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SYM  = 4'd1;   // window read issued
  localparam logic [3:0] S_SYMW = 4'd2;   // symbol captured
  localparam logic [3:0] S_MAC  = 4'd3;   // issue alpha/transition reads
  localparam logic [3:0] S_MACD = 4'd4;   // drain the mac pipeline
  localparam logic [3:0] S_MUL  = 4'd5;   // times emission
  localparam logic [3:0] S_UW   = 4'd6;   // write u, add to scale
  localparam logic [3:0] S_CHK  = 4'd7;   // zero scale check
  localparam logic [3:0] S_DRD  = 4'd8;   // read u for division
  localparam logic [3:0] S_DLD  = 4'd9;   // load divider
  localparam logic [3:0] S_DIV  = 4'd10;  // one quotient bit a cycle
  localparam logic [3:0] S_DWR  = 4'd11;  // write new alpha
  localparam logic [3:0] S_LOG  = 4'd12;  // normalise scale
  localparam logic [3:0] S_LOGA = 4'd13;  // add log term
  localparam logic [3:0] S_OUT  = 4'd14;  // hand result to output slot

  // configuration
  logic [LenW-1:0]    win_len_q;
  score_t             thr_q;
  logic [MarginW-1:0] margin_q;

  // window bookkeeping
  logic [WinAW-1:0] head_q;
  logic [LenW-1:0]  fill_q;
  logic [LenW-1:0]  len_q;

  // sequencer
  logic [3:0]       state_q;
  logic [WinAW-1:0] t_q;
  state_idx_t       j_q, i_q;
  logic             rd1_v_q, prod_v_q;
  logic [4:0]       dcnt_q;

  // datapath
  logic [StW-1:0]    sym_q;
  logic [AccW-1:0]   acc_q;
  logic [ProdW-1:0]  prod_q;
  logic [UProdW-1:0] uprod_q;
  logic [SW-1:0]     s_q, rem_q, norm_q;
  logic [AlphaW-1:0] quot_q;
  logic [PW-1:0]     p_q;
  score_t            total_q;

  // output slot
  logic   out_valid_q;
  score_t score_q;
  logic   belongs_q;

  // memories
  logic [StW-1:0]    win_mem   [MaxWindow];
  prob_t             trans_mem [NumStates*NumStates];
  prob_t             emis_mem  [NumStates*NumStates];
  prob_t             init_mem  [NumStates];
  logic [AlphaW-1:0] alpha_mem [NumStates];
  logic [UW-1:0]     u_mem     [NumStates];

  logic [StW-1:0]    win_rd_q;
  prob_t             trans_rd_q, emis_rd_q, init_rd_q;
  logic [AlphaW-1:0] alpha_rd_q;
  logic [UW-1:0]     u_rd_q;

  // handshakes
  logic in_acc, obs_acc, cfg_acc, out_free;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign obs_acc     = in_acc && (kind_i == KIND_OBS);
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign belongs_o   = belongs_q;

  // window update for an observe item
  logic [LenW-1:0]  len_c, drop_c, fill_c, fill_n;
  logic [WinAW-1:0] head_c, waddr_c;
  logic             keep_c, run_c;

  always_comb begin
    if (win_len_q == '0) begin
      len_c = LenW'(1);
    end else if (win_len_q > LenW'(MaxWindow)) begin
      len_c = LenW'(MaxWindow);
    end else begin
      len_c = win_len_q;
    end
    keep_c  = (fill_q >= len_c);
    drop_c  = fill_q - len_c + LenW'(1);
    head_c  = keep_c ? head_q + drop_c[WinAW-1:0] : head_q;
    fill_c  = keep_c ? len_c - LenW'(1) : fill_q;
    waddr_c = head_c + fill_c[WinAW-1:0];
    fill_n  = fill_c + LenW'(1);
    run_c   = (fill_n == len_c);
  end

  // divider step
  logic [SW:0]   div_x;
  logic          div_ge;
  logic [SW-1:0] rem_d;

  always_comb begin
    div_x  = (dcnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    div_ge = (div_x >= {1'b0, s_q});
    rem_d  = div_ge ? SW'(div_x - {1'b0, s_q}) : div_x[SW-1:0];
  end

  // log term: ((p - frac) * ln2 + ln(1 + k/32) + half) floored to q8
  logic signed [23:0] ln_q16;
  logic signed [15:0] ln_q8;

  always_comb begin
    ln_q16 = (24'(signed'({1'b0, p_q})) - 24'sd16) * 24'(Ln2Q16)
             + 24'(signed'({1'b0, ln_frac(norm_q[SW-2 -: 5])})) + 24'sd128;
    ln_q8  = 16'(ln_q16 >>> 8);
  end

  // threshold compare, widened so the difference cannot wrap
  logic signed [ScoreW+1:0] lim_c;
  assign lim_c = signed'({{2{thr_q[ScoreW-1]}}, thr_q}) -
                 signed'({{(ScoreW+2-MarginW){1'b0}}, margin_q});

  logic last_t;
  assign last_t = (LenW'(t_q) == len_q - LenW'(1));

  // memory ports
  always_ff @(posedge clk_i) begin
    if (obs_acc) begin
      win_mem[waddr_c] <= symbol_i;
    end
    win_rd_q <= win_mem[head_q + t_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == KIND_TRANS) begin
      trans_mem[{row_i, col_i}] <= value_i;
    end
    if (in_acc && kind_i == KIND_EMIS) begin
      emis_mem[{row_i, col_i}] <= value_i;
    end
    if (in_acc && kind_i == KIND_INIT) begin
      init_mem[row_i] <= value_i;
    end
    trans_rd_q <= trans_mem[{i_q, j_q}];
    emis_rd_q  <= emis_mem[{j_q, sym_q}];
    init_rd_q  <= init_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DWR) begin
      alpha_mem[j_q] <= quot_q;
    end
    if (state_q == S_UW) begin
      u_mem[j_q] <= uprod_q[UProdW-1:FracBits];
    end
    alpha_rd_q <= alpha_mem[i_q];
    u_rd_q     <= u_mem[j_q];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= LenW'(MaxWindow);
      thr_q     <= '0;
      margin_q  <= MarginW'(12800);
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_WIN_LEN: win_len_q <= cfg_data_i[LenW-1:0];
        REG_THRESH:  thr_q     <= signed'(cfg_data_i);
        REG_MARGIN:  margin_q  <= cfg_data_i[MarginW-1:0];
        default:     ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd1_v_q) begin
      prod_q <= alpha_rd_q * trans_rd_q;
    end
    if (state_q == S_SYMW) begin
      acc_q <= '0;
      sym_q <= win_rd_q;
    end else if (state_q == S_UW) begin
      acc_q <= '0;
    end else if (rd1_v_q && t_q == '0) begin
      acc_q <= AccW'(init_rd_q);
    end else if (prod_v_q) begin
      acc_q <= acc_q + AccW'(prod_q[ProdW-1:FracBits]);
    end
    if (state_q == S_MUL) begin
      uprod_q <= acc_q * emis_rd_q;
    end
    case (state_q)
      S_IDLE: begin
        total_q <= '0;
        s_q     <= '0;
      end
      S_UW: s_q <= s_q + SW'(uprod_q[UProdW-1:FracBits]);
      S_DLD: begin
        rem_q  <= SW'(u_rd_q);
        quot_q <= '0;
      end
      S_DIV: begin
        rem_q  <= rem_d;
        quot_q <= {quot_q[AlphaW-2:0], div_ge};
      end
      S_CHK: begin
        if (s_q == '0) begin
          total_q <= {1'b1, {(ScoreW-1){1'b0}}};
        end
        norm_q <= s_q;
      end
      S_LOG: begin
        if (!norm_q[SW-1] && p_q != '0) begin
          norm_q <= {norm_q[SW-2:0], 1'b0};
        end
      end
      S_LOGA: begin
        // at most 64 terms of a few thousand each: no overflow in 32 bits
        total_q <= total_q + ScoreW'(ln_q8);
        s_q     <= '0;
      end
      default: ;
    endcase
  end

  // sequencer and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      t_q         <= '0;
      j_q         <= '0;
      i_q         <= '0;
      rd1_v_q     <= 1'b0;
      prod_v_q    <= 1'b0;
      dcnt_q      <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      score_q     <= '0;
      belongs_q   <= 1'b0;
    end else begin
      rd1_v_q  <= (state_q == S_MAC);
      prod_v_q <= rd1_v_q && (t_q != '0);
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (obs_acc) begin
            head_q <= head_c;
            fill_q <= fill_n;
            len_q  <= len_c;
            t_q    <= '0;
            if (run_c) begin
              state_q <= S_SYM;
            end
          end
        end
        S_SYM: state_q <= S_SYMW;
        S_SYMW: begin
          j_q     <= '0;
          i_q     <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          i_q <= i_q + StW'(1);
          if (t_q == '0 || i_q == StW'(NumStates-1)) begin
            state_q <= S_MACD;
          end
        end
        S_MACD: begin
          if (!rd1_v_q && !prod_v_q) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_UW;
        S_UW: begin
          i_q <= '0;
          if (j_q == StW'(NumStates-1)) begin
            state_q <= S_CHK;
          end else begin
            j_q     <= j_q + StW'(1);
            state_q <= S_MAC;
          end
        end
        S_CHK: begin
          j_q <= '0;
          p_q <= PW'(SW-1);
          // a zero scale ends the pass with the lowest score
          state_q <= (s_q == '0) ? S_OUT : S_DRD;
        end
        S_DRD: state_q <= S_DLD;
        S_DLD: begin
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'(AlphaW-1)) begin
            state_q <= S_DWR;
          end
        end
        S_DWR: begin
          if (j_q == StW'(NumStates-1)) begin
            state_q <= S_LOG;
          end else begin
            j_q     <= j_q + StW'(1);
            state_q <= S_DRD;
          end
        end
        S_LOG: begin
          if (!norm_q[SW-1] && p_q != '0) begin
            p_q <= p_q - PW'(1);
          end else begin
            state_q <= S_LOGA;
          end
        end
        S_LOGA: begin
          if (last_t) begin
            state_q <= S_OUT;
          end else begin
            t_q     <= t_q + WinAW'(1);
            state_q <= S_SYM;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            score_q     <= total_q;
            belongs_q   <= (signed'({{2{total_q[ScoreW-1]}}, total_q}) >= lim_c);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (s_q != '0))
    else $error("divider running on a zero scale");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWR) |-> (quot_q <= AlphaW'(1 << FracBits)))
    else $error("normalised alpha above one");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LenW'(MaxWindow))
    else $error("window fill count beyond capacity");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished result not presented");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the windowed hmm forward scorer
`timescale 1ns / 100ps

module testbench;
  import hwfs_pkg::*;

  // run cap, well above the slowest correct run
  localparam int unsigned CycleLimit = 2_000_000;
  // quiet cycles after the last result before a register write or the end
  localparam int unsigned SettleCycles = 50;

  typedef struct {
    score_t score;
    logic   belongs;
  } window_score_t;

  // forward-pass predictor plus the queue of scores still owed by the block
  class forward_score_model;
    longint unsigned trans_p[256];
    longint unsigned emis_p[256];
    longint unsigned init_p[16];
    longint unsigned alpha_p[16];
    bit [3:0] win_sym[64];
    int unsigned head;
    int unsigned fill;
    bit [6:0] win_len;
    longint thresh;
    longint slack;
    window_score_t owed_scores[$];
    int errors;
    int checked;
    int zero_windows;
    longint ln_tab[32] = '{
      0, 2017, 3973, 5873, 7719, 9515, 11262, 12965,
      14624, 16242, 17822, 19364, 20870, 22343, 23784, 25193,
      26573, 27924, 29248, 30546, 31818, 33067, 34292, 35494,
      36675, 37835, 38975, 40095, 41197, 42280, 43345, 44394};

    function new();
      win_len = 7'd64;
      thresh = 0;
      slack = 12800;
      head = 0;
      fill = 0;
      errors = 0;
      checked = 0;
      zero_windows = 0;
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void set_reg(reg_idx_e idx, logic [31:0] d);
      case (idx)
        REG_WIN_LEN: win_len = d[6:0];
        REG_THRESH:  thresh = longint'($signed(d));
        REG_MARGIN:  slack = longint'(d[15:0]);
        default: ;
      endcase
    endfunction

    // ln(s / 2^16) in q8: octave term plus five-bit mantissa lookup, rounded up at half
    function longint ln_q8(longint unsigned s);
      int p;
      longint unsigned k;
      longint v;
      p = 63;
      while (p > 0 && s[p] == 1'b0) p--;
      if (p >= 5) k = (s >> (p - 5)) & 31;
      else k = (s << (5 - p)) & 31;
      v = longint'(p - 16) * 45426 + ln_tab[k] + 128;
      return v >>> 8;
    endfunction

    function longint forward_pass();
      longint unsigned u[16];
      longint unsigned s;
      longint unsigned acc;
      longint unsigned e;
      longint total;
      int unsigned sym;
      total = 0;
      for (int unsigned t = 0; t < fill; t++) begin
        sym = win_sym[(head + t) % 64];
        s = 0;
        for (int j = 0; j < 16; j++) begin
          e = emis_p[j*16 + sym];
          if (t == 0) begin
            u[j] = (init_p[j] * e) >> 16;
          end else begin
            acc = 0;
            for (int i = 0; i < 16; i++) acc += (alpha_p[i] * trans_p[i*16 + j]) >> 16;
            u[j] = (acc * e) >> 16;
          end
          s += u[j];
        end
        // a step with no mass pins the score to the floor
        if (s == 0) begin
          zero_windows++;
          return -64'sd2147483648;
        end
        for (int j = 0; j < 16; j++) alpha_p[j] = (u[j] << 16) / s;
        total += ln_q8(s);
      end
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      return total;
    endfunction

    function void note_item(kind_e k, logic [3:0] r, logic [3:0] c, prob_t v,
                            logic [3:0] sym);
      int unsigned len;
      longint sc;
      window_score_t rec;
      case (k)
        KIND_TRANS: trans_p[r*16 + c] = v;
        KIND_EMIS:  emis_p[r*16 + c] = v;
        KIND_INIT:  init_p[r] = v;
        default: begin
          len = win_len;
          if (len < 1) len = 1;
          if (len > 64) len = 64;
          // drop oldest symbols, also after the length was lowered
          while (fill >= len) begin
            head = (head + 1) % 64;
            fill--;
          end
          win_sym[(head + fill) % 64] = sym;
          fill++;
          if (fill == len) begin
            sc = forward_pass();
            rec.score = sc[31:0];
            rec.belongs = (sc >= thresh - slack);
            owed_scores.insert(owed_scores.size(), rec);
          end
        end
      endcase
    endfunction

    task check_result(score_t sc, logic bel);
      window_score_t exp_rec;
      if (owed_scores.size() == 0) begin
        report_mismatch($sformatf("score %0d with none expected", sc));
        return;
      end
      exp_rec = owed_scores.pop_front();
      checked++;
      if (sc !== exp_rec.score)
        report_mismatch($sformatf("score %0d, expected %0d", sc, exp_rec.score));
      if (bel !== exp_rec.belongs)
        report_mismatch($sformatf("belongs %0b, expected %0b", bel, exp_rec.belongs));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] kind = KIND_TRANS;
  logic [3:0] row = '0;
  logic [3:0] col = '0;
  prob_t value = '0;
  logic [3:0] symbol = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_WIN_LEN;
  logic [31:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  score_t score;
  logic belongs;
  logic cfg_ready;

  forward_score_model scorer = new();
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
  int unsigned burst_left = 0;

  hmm_window_forward_scorer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .row_i       (row),
    .col_i       (col),
    .value_i     (value),
    .symbol_i    (symbol),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .score_o     (score),
    .belongs_o   (belongs),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: takes results and stalls on a random pattern that it re-chooses per span
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned span;
    stall_pct = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) scorer.check_result(score, belongs);
      if (span == 0) begin
        span = 32;
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;    // stretches with no stall at all
          2:    stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      span--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // one item: optional burst gap first, then offer until accepted; valid stays high on return
  task automatic send_item(kind_e k, logic [3:0] r, logic [3:0] c, prob_t v,
                           logic [3:0] sym);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    row <= r;
    col <= c;
    value <= v;
    symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scorer.note_item(k, r, c, v, sym);
  endtask

  task automatic observe(logic [3:0] sym);
    send_item(KIND_OBS, 4'($urandom), 4'($urandom), prob_t'($urandom), sym);
  endtask

  // stop offering and wait until every owed score has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scorer.owed_scores.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scorer.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [6:0] len, logic [31:0] thr, logic [15:0] mrg);
    write_reg(REG_WIN_LEN, 32'(len));
    write_reg(REG_THRESH, thr);
    write_reg(REG_MARGIN, 32'(mrg));
  endtask

  task automatic random_item();
    prob_t v;
    if ($urandom_range(0, 99) < 12) begin
      v = ($urandom_range(0, 3) == 0) ? prob_t'($urandom_range(0, 262143))
                                      : prob_t'($urandom_range(1000, 12000));
      send_item(kind_e'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), v, 4'($urandom));
    end else begin
      observe(4'($urandom_range(0, 15)));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(7'd3, 32'd0, 16'd12800);

    // every table entry gets written before any window can read it;
    // symbol 15 has no emission mass anywhere, so it forces a zero-scale step
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        send_item(KIND_TRANS, 4'(i), 4'(j), prob_t'($urandom_range(1000, 8000)), 4'($urandom));
        send_item(KIND_EMIS, 4'(i), 4'(j),
                  (j == 15) ? prob_t'(0) : prob_t'($urandom_range(1000, 8000)), 4'($urandom));
      end
      send_item(KIND_INIT, 4'(i), 4'd0, prob_t'($urandom_range(2000, 8000)), 4'($urandom));
    end
    // full-scale probabilities
    send_item(KIND_EMIS, 4'd3, 4'd2, prob_t'(262143), 4'd0);
    send_item(KIND_TRANS, 4'd15, 4'd15, prob_t'(262143), 4'd0);

    // directed: every symbol through a three-symbol window, zero-scale case included
    for (int s = 0; s < 16; s++) observe(4'(s));
    drain();
    // threshold extremes: nothing can reach the top, everything clears the bottom
    set_regs(7'd3, 32'h7fff_ffff, 16'd0);
    observe(4'd2);
    observe(4'd7);
    drain();
    set_regs(7'd3, 32'h8000_0000, 16'hffff);
    observe(4'd0);
    observe(4'd15);
    drain();

    // oversized length clamps to the full 64-symbol window
    set_regs(7'd127, 32'hffff_c000, 16'd12800);
    for (int n = 0; n < 66; n++) observe(4'($urandom_range(0, 14)));
    drain();
    // length lowered while full: oldest symbols drop at once
    write_reg(REG_WIN_LEN, 32'd2);
    observe(4'd1);
    observe(4'd4);
    drain();
    // zero length behaves as one
    write_reg(REG_WIN_LEN, 32'd0);
    observe(4'd6);
    observe(4'd15);
    drain();

    // random phases on short windows with thresholds near typical scores
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(7'($urandom_range(1, 4)), 32'(-$urandom_range(0, 20000)),
               16'($urandom_range(0, 65535)));
      // one phase holds the receiver off long enough for the block to back up
      if (ph == 2) hold_cycles = 12000;
      for (int n = 0; n < 25; n++) random_item();
      drain();
    end

    $display("tb: %0d window scores checked, %0d of them with an empty step;",
             scorer.checked, scorer.zero_windows);
    $display("tb: window lengths 0 to 127, threshold and margin extremes, long output hold");
    if (scorer.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* hmm_window_forward_scorer_unit.f */
sv/hwfs_pkg.sv
sv/hmm_window_forward_scorer_unit.sv
tb/testbench.sv
